>>> rtl/response_header_phase_tracker_assert.svh
// assertion macros shared by the tracker rtl
`ifndef RESPONSE_HEADER_PHASE_TRACKER_ASSERT_SVH
`define RESPONSE_HEADER_PHASE_TRACKER_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define RHPT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tracker check failed");

// next-cycle implication, checked on every rising clock edge outside reset
`define RHPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tracker check failed");

`endif

>>> rtl/rhpt_pkg.sv
`default_nettype none

package rhpt_pkg;

   // command codes
   localparam logic [2:0] CMD_RESET    = 3'd0;
   localparam logic [2:0] CMD_BEGIN    = 3'd1;
   localparam logic [2:0] CMD_STATUS   = 3'd2;
   localparam logic [2:0] CMD_END      = 3'd3;
   localparam logic [2:0] CMD_TRAILERS = 3'd4;
   localparam logic [2:0] CMD_FIELD    = 3'd5;

   // block phase codes
   localparam logic [2:0] PH_NONE  = 3'd0;
   localparam logic [2:0] PH_AWAIT = 3'd1;
   localparam logic [2:0] PH_INFO  = 3'd2;
   localparam logic [2:0] PH_FINAL = 3'd3;
   localparam logic [2:0] PH_TRAIL = 3'd4;

   // field class codes
   localparam logic [1:0] FC_STATUS   = 2'd0;
   localparam logic [1:0] FC_REGULAR  = 2'd1;
   localparam logic [1:0] FC_INVALID  = 2'd2;
   localparam logic [1:0] FC_REJECTED = 2'd3;

   // field route codes
   localparam logic [1:0] RT_STATUS   = 2'd0;
   localparam logic [1:0] RT_PROCESS  = 2'd1;
   localparam logic [1:0] RT_IGNORE   = 2'd2;
   localparam logic [1:0] RT_TERMINAL = 2'd3;

   // informational status range is [INFO_LOW, INFO_HIGH)
   localparam logic [9:0] INFO_LOW  = 10'd100;
   localparam logic [9:0] INFO_HIGH = 10'd200;

   // ":status" as seven bytes, first byte on top
   localparam logic [55:0] STATUS_NAME_HEAD = 56'h3A737461747573;
   localparam logic [15:0] STATUS_NAME_LEN  = 16'd7;
   localparam logic [7:0]  COLON_BYTE       = 8'h3A;

   // one input beat
   typedef struct packed {
      logic [2:0]  command;
      logic [9:0]  status_code;
      logic        stream_end;
      logic        name_present;
      logic [15:0] name_length;
      logic [55:0] name_head;
      logic        bad_regular;
   } req_item_type;

   // one result beat
   typedef struct packed {
      logic [2:0] phase_out;
      logic       accepted;
      logic [1:0] name_class;
      logic [1:0] field_route;
      logic       status_fields_allowed;
      logic       metadata_trailing;
      logic       terminal_on_abandon;
   } rsp_item_type;

endpackage

`default_nettype wire

>>> rtl/rhpt_classify.sv
`default_nettype none

module rhpt_classify (
   input  wire logic [2:0]  command,
   input  wire logic        name_present,
   input  wire logic [15:0] name_length,
   input  wire logic [55:0] name_head,
   input  wire logic        bad_regular,
   output logic [1:0]       name_class
);

   logic is_pseudo;
   logic is_status_name;
   logic is_field_cmd;

   // pseudo-header check on the first name byte
   assign is_pseudo      = (name_head[55:48] == rhpt_pkg::COLON_BYTE);
   assign is_status_name = !bad_regular
                           && (name_length == rhpt_pkg::STATUS_NAME_LEN)
                           && (name_head == rhpt_pkg::STATUS_NAME_HEAD);
   assign is_field_cmd   = (command == rhpt_pkg::CMD_FIELD);

   // class of the field name; zero for every other command
   always_comb begin
      if (!is_field_cmd) begin
         name_class = rhpt_pkg::FC_STATUS;
      end else if (!name_present) begin
         name_class = rhpt_pkg::FC_REJECTED;
      end else if (name_length == 16'd0) begin
         name_class = bad_regular ? rhpt_pkg::FC_INVALID : rhpt_pkg::FC_REJECTED;
      end else if (is_pseudo) begin
         name_class = is_status_name ? rhpt_pkg::FC_STATUS : rhpt_pkg::FC_REJECTED;
      end else begin
         name_class = bad_regular ? rhpt_pkg::FC_INVALID : rhpt_pkg::FC_REGULAR;
      end
   end

endmodule

`default_nettype wire

>>> rtl/rhpt_phase.sv
`default_nettype none

module rhpt_phase (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire rhpt_pkg::req_item_type item,
   input  wire logic [1:0]             name_class,
   output rhpt_pkg::rsp_item_type      result
);

   logic [2:0] phase_ff;
   logic [2:0] phase_in;
   logic       final_seen_ff;
   logic       final_seen_in;
   logic       trailers_only_ff;
   logic       trailers_only_in;
   logic       accepted;
   logic [1:0] route;
   logic [2:0] phase_report;
   logic       status_is_info;

   assign status_is_info = (item.status_code >= rhpt_pkg::INFO_LOW)
                           && (item.status_code < rhpt_pkg::INFO_HIGH);

   // next state and the trailers-only accept
   always_comb begin
      phase_in         = phase_ff;
      final_seen_in    = final_seen_ff;
      trailers_only_in = trailers_only_ff;
      accepted         = 1'b0;
      case (item.command)
         rhpt_pkg::CMD_RESET: begin
            phase_in         = rhpt_pkg::PH_NONE;
            final_seen_in    = 1'b0;
            trailers_only_in = 1'b0;
         end
         rhpt_pkg::CMD_BEGIN: begin
            phase_in         = final_seen_ff ? rhpt_pkg::PH_TRAIL : rhpt_pkg::PH_AWAIT;
            trailers_only_in = 1'b0;
         end
         rhpt_pkg::CMD_STATUS: begin
            if (phase_ff == rhpt_pkg::PH_AWAIT) begin
               if (status_is_info) begin
                  phase_in = rhpt_pkg::PH_INFO;
               end else begin
                  phase_in      = rhpt_pkg::PH_FINAL;
                  final_seen_in = 1'b1;
               end
            end
         end
         rhpt_pkg::CMD_END: begin
            phase_in         = rhpt_pkg::PH_NONE;
            trailers_only_in = 1'b0;
         end
         rhpt_pkg::CMD_TRAILERS: begin
            if (item.stream_end && (phase_ff == rhpt_pkg::PH_FINAL) && !trailers_only_ff) begin
               trailers_only_in = 1'b1;
               accepted         = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // route the classified field against the current phase
   always_comb begin
      route = rhpt_pkg::RT_STATUS;
      if (item.command == rhpt_pkg::CMD_FIELD) begin
         case (name_class)
            rhpt_pkg::FC_STATUS: begin
               route = (phase_ff == rhpt_pkg::PH_AWAIT) ? rhpt_pkg::RT_STATUS
                                                         : rhpt_pkg::RT_TERMINAL;
            end
            rhpt_pkg::FC_REGULAR: begin
               if (phase_ff == rhpt_pkg::PH_INFO) begin
                  route = rhpt_pkg::RT_IGNORE;
               end else if ((phase_ff == rhpt_pkg::PH_FINAL)
                            || (phase_ff == rhpt_pkg::PH_TRAIL)) begin
                  route = rhpt_pkg::RT_PROCESS;
               end else begin
                  route = rhpt_pkg::RT_TERMINAL;
               end
            end
            rhpt_pkg::FC_INVALID: begin
               if ((phase_ff == rhpt_pkg::PH_INFO) || (phase_ff == rhpt_pkg::PH_FINAL)
                   || (phase_ff == rhpt_pkg::PH_TRAIL)) begin
                  route = rhpt_pkg::RT_IGNORE;
               end else begin
                  route = rhpt_pkg::RT_TERMINAL;
               end
            end
            default: begin
               route = rhpt_pkg::RT_TERMINAL;
            end
         endcase
      end
   end

   // end reports the phase that closed
   assign phase_report = (item.command == rhpt_pkg::CMD_END) ? phase_ff : phase_in;

   // result fields, flags taken from the state after the step
   always_comb begin
      result.phase_out             = phase_report;
      result.accepted              = accepted;
      result.name_class            = name_class;
      result.field_route           = route;
      result.status_fields_allowed = item.stream_end
                                     && ((phase_in == rhpt_pkg::PH_FINAL)
                                         || (phase_in == rhpt_pkg::PH_TRAIL));
      result.metadata_trailing     = (phase_in == rhpt_pkg::PH_TRAIL)
                                     || ((phase_in == rhpt_pkg::PH_FINAL) && trailers_only_in);
      result.terminal_on_abandon   = (phase_in != rhpt_pkg::PH_NONE);
   end

   // tracker state, written when a beat moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= rhpt_pkg::PH_NONE;
         final_seen_ff    <= 1'b0;
         trailers_only_ff <= 1'b0;
      end else if (advance) begin
         phase_ff         <= phase_in;
         final_seen_ff    <= final_seen_in;
         trailers_only_ff <= trailers_only_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/response_header_phase_tracker.sv
// path: a request is held in the input register, then in the result register, before its response is offered
// throughput: one beat per cycle while rsp_ready holds; the phase update sits between the two registers
// a stalled response holds the result register, and the input register fills behind it
// reset: synchronous, active high; clears both valid flags, the phase to none and both flags
// no clearing pass: the block is ready for a request as soon as reset ends
`default_nettype none

`include "response_header_phase_tracker_assert.svh"

module response_header_phase_tracker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_command,
   input  wire logic [9:0]  req_status_code,
   input  wire logic        req_stream_end,
   input  wire logic        req_name_present,
   input  wire logic [15:0] req_name_length,
   input  wire logic [55:0] req_name_head,
   input  wire logic        req_bad_regular,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_phase_out,
   output logic             rsp_accepted,
   output logic [1:0]       rsp_name_class,
   output logic [1:0]       rsp_field_route,
   output logic             rsp_status_fields_allowed,
   output logic             rsp_metadata_trailing,
   output logic             rsp_terminal_on_abandon
);

   rhpt_pkg::req_item_type item_ff;
   logic                   item_valid_ff;
   rhpt_pkg::rsp_item_type result_ff;
   logic                   result_valid_ff;
   rhpt_pkg::rsp_item_type result_in;
   logic [1:0]             name_class;
   logic                   advance;

   // the held beat moves on when the result register is free or draining
   assign advance   = item_valid_ff && (!result_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_ready) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.command      <= req_command;
         item_ff.status_code  <= req_status_code;
         item_ff.stream_end   <= req_stream_end;
         item_ff.name_present <= req_name_present;
         item_ff.name_length  <= req_name_length;
         item_ff.name_head    <= req_name_head;
         item_ff.bad_regular  <= req_bad_regular;
      end
   end

   // field name classifier
   rhpt_classify u_classify (
      .command      (item_ff.command),
      .name_present (item_ff.name_present),
      .name_length  (item_ff.name_length),
      .name_head    (item_ff.name_head),
      .bad_regular  (item_ff.bad_regular),
      .name_class   (name_class)
   );

   // phase state and routing
   rhpt_phase u_phase (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .item       (item_ff),
      .name_class (name_class),
      .result     (result_in)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         result_valid_ff <= 1'b0;
      end else if (advance) begin
         result_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         result_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   // response ports
   assign rsp_valid                 = result_valid_ff;
   assign rsp_phase_out             = result_ff.phase_out;
   assign rsp_accepted              = result_ff.accepted;
   assign rsp_name_class            = result_ff.name_class;
   assign rsp_field_route           = result_ff.field_route;
   assign rsp_status_fields_allowed = result_ff.status_fields_allowed;
   assign rsp_metadata_trailing     = result_ff.metadata_trailing;
   assign rsp_terminal_on_abandon   = result_ff.terminal_on_abandon;

   // a newly accepted trailers-only field leaves the phase final and trailing
   `RHPT_ASSERT_NOW(a_accept_final, clock, reset, rsp_valid && rsp_accepted,
                    (rsp_phase_out == rhpt_pkg::PH_FINAL) && rsp_metadata_trailing)

   // status fields are only allowed inside an open block
   `RHPT_ASSERT_NOW(a_status_open, clock, reset, rsp_valid && rsp_status_fields_allowed,
                    rsp_terminal_on_abandon)

   // rejected fields always route to a protocol error
   `RHPT_ASSERT_NOW(a_reject_terminal, clock, reset,
                    rsp_valid && (rsp_name_class == rhpt_pkg::FC_REJECTED),
                    rsp_field_route == rhpt_pkg::RT_TERMINAL)

   // a held beat that cannot move stays held
   `RHPT_ASSERT_NEXT(a_item_held, clock, reset, item_valid_ff && !advance, item_valid_ff)

endmodule

`default_nettype wire
